### rtl/core/assert_macros.svh
// Assertion macros shared by the core RTL.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define PMCD_ASSERT(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`define PMCD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define PMCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define PMCD_ASSERT(label, clk, rst, expr, msg)
`define PMCD_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define PMCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

### rtl/core/pmcd_pkg.sv
// Types and constants of the motor command decoder.
// No dependencies.
package pmcd_pkg;

   typedef logic        [7:0]  byte_type;
   typedef logic signed [7:0]  cmd_type;
   typedef logic signed [17:0] drive_type;
   typedef logic        [9:0]  scale_type;

   typedef enum logic [1:0] {
      MODE_BRAKE = 2'd0,
      MODE_DUTY  = 2'd1,
      MODE_RPM   = 2'd2
   } drive_mode_type;

   typedef enum logic [1:0] {
      CSR_NODE_ID     = 2'd0,
      CSR_MOTOR_IS_DC = 2'd1,
      CSR_RPM_SCALE   = 2'd2
   } csr_index_type;

   // frame command codes
   localparam byte_type CMD_M1_FWD   = 8'd0;
   localparam byte_type CMD_M1_REV   = 8'd1;
   localparam byte_type CMD_M2_FWD   = 8'd4;
   localparam byte_type CMD_M2_REV   = 8'd5;
   localparam byte_type CMD_M2_7BIT  = 8'd6;
   localparam byte_type CMD_M1_7BIT  = 8'd7;

   localparam logic [6:0]  MID_POINT       = 7'd64;
   localparam logic [16:0] DUTY_FULL       = 17'd32767;
   localparam scale_type   RPM_SCALE_RESET = 10'd126;

   typedef struct packed {
      byte_type  node_id;
      logic      motor_is_dc;
      scale_type rpm_scale;
   } cfg_type;

   typedef struct packed {
      logic           frame_valid;
      logic           addressed;
      cmd_type        command_value;
      logic           command_changed;
      drive_mode_type drive_mode;
      drive_type      drive_value;
   } result_type;

endpackage

### rtl/core/pmcd_decode.sv
// Frame check, command update and drive derivation for one received byte.
// Depends on pmcd_pkg.
module pmcd_decode (
   input  pmcd_pkg::byte_type   rx_byte,
   input  pmcd_pkg::byte_type   win_addr,
   input  pmcd_pkg::byte_type   win_cmd,
   input  pmcd_pkg::byte_type   win_payload,
   input  pmcd_pkg::cmd_type    cur_cmd,
   input  pmcd_pkg::cfg_type    cfg,
   output pmcd_pkg::result_type res
);

   logic [6:0]         sum7;
   logic               valid;
   logic               cmd_mine;
   logic               for_me;
   pmcd_pkg::cmd_type  next_cmd;
   logic [7:0]         mag;
   logic [16:0]        duty_q;
   logic [16:0]        duty_c;
   logic signed [18:0] rpm_full;

   always_comb begin
      sum7  = 7'(win_addr + win_cmd + win_payload);
      valid = ({1'b0, sum7} == rx_byte);

      if (cfg.node_id[0] == 1'b0) begin
         cmd_mine = (win_cmd == pmcd_pkg::CMD_M1_FWD) || (win_cmd == pmcd_pkg::CMD_M1_REV)
                 || (win_cmd == pmcd_pkg::CMD_M1_7BIT);
      end else begin
         cmd_mine = (win_cmd == pmcd_pkg::CMD_M2_FWD) || (win_cmd == pmcd_pkg::CMD_M2_REV)
                 || (win_cmd == pmcd_pkg::CMD_M2_7BIT);
      end
      for_me = valid && win_addr[7] && (win_addr[6:0] == cfg.node_id[7:1]) && cmd_mine;

      next_cmd = cur_cmd;
      if (for_me && !win_payload[7]) begin
         case (win_cmd) inside
            pmcd_pkg::CMD_M1_FWD, pmcd_pkg::CMD_M2_FWD: begin
               next_cmd = $signed({1'b0, win_payload[6:0]});
            end
            pmcd_pkg::CMD_M1_REV, pmcd_pkg::CMD_M2_REV: begin
               next_cmd = -$signed({1'b0, win_payload[6:0]});
            end
            default: begin
               // (payload - 64) * 2, odd when above midpoint
               next_cmd = $signed({7'(win_payload[6:0] - pmcd_pkg::MID_POINT),
                                   win_payload[6:0] > pmcd_pkg::MID_POINT});
            end
         endcase
      end

      // round(m * 32767 / 127) = 258 * m + (m >= 64) for m up to 128
      mag      = next_cmd[7] ? 8'(-next_cmd) : next_cmd;
      duty_q   = {1'b0, mag, 8'd0} + {8'd0, mag, 1'b0} + {16'd0, mag >= 8'd64};
      duty_c   = (duty_q > pmcd_pkg::DUTY_FULL) ? pmcd_pkg::DUTY_FULL : duty_q;
      rpm_full = $signed({{11{next_cmd[7]}}, next_cmd}) * $signed({9'd0, cfg.rpm_scale});

      res.frame_valid     = valid;
      res.addressed       = for_me;
      res.command_value   = next_cmd;
      res.command_changed = (next_cmd != cur_cmd);
      if (next_cmd == 8'sd0) begin
         res.drive_mode  = pmcd_pkg::MODE_BRAKE;
         res.drive_value = '0;
      end else if (cfg.motor_is_dc) begin
         res.drive_mode  = pmcd_pkg::MODE_DUTY;
         res.drive_value = next_cmd[7] ? -$signed({1'b0, duty_c}) : $signed({1'b0, duty_c});
      end else begin
         res.drive_mode  = pmcd_pkg::MODE_RPM;
         res.drive_value = rpm_full[17:0];
      end
   end

endmodule

### rtl/core/packetized_motor_command_decoder_core.sv
// An accepted req beat passes the input register and then the result register to its rsp beat.
// Throughput: one byte per cycle, but a stalled rsp holds; the input stage keeps one more beat.
// Reset (synchronous, active high): byte window and stored command cleared, node id 0,
// motor_is_dc 0, rpm_scale 126, both pipeline stages emptied. No clearing pass.
// Top level of the motor command decoder; uses pmcd_pkg, pmcd_decode and assert_macros.svh.
`include "assert_macros.svh"

module packetized_motor_command_decoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [0] frame_valid, [1] addressed, [9:2] command_value,
                                    // [10] command_changed, [28:11] drive_value, rest zero
   output logic [1:0]  rsp_tuser,   // [1:0] drive_mode
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [9:0]  csr_wdata
);

   logic                 in_valid_ff;
   pmcd_pkg::byte_type   in_byte_ff;
   logic                 out_valid_ff;
   pmcd_pkg::result_type out_ff;
   pmcd_pkg::byte_type   win_ff [3];
   pmcd_pkg::cmd_type    cmd_ff;
   pmcd_pkg::cfg_type    cfg_ff;
   pmcd_pkg::result_type res_in;
   logic                 advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.node_id     <= '0;
         cfg_ff.motor_is_dc <= 1'b0;
         cfg_ff.rpm_scale   <= pmcd_pkg::RPM_SCALE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            pmcd_pkg::CSR_NODE_ID:     cfg_ff.node_id     <= csr_wdata[7:0];
            pmcd_pkg::CSR_MOTOR_IS_DC: cfg_ff.motor_is_dc <= csr_wdata[0];
            pmcd_pkg::CSR_RPM_SCALE:   cfg_ff.rpm_scale   <= csr_wdata;
            default: ;
         endcase
      end
   end

   pmcd_decode u_decode (
      .rx_byte     (in_byte_ff),
      .win_addr    (win_ff[0]),
      .win_cmd     (win_ff[1]),
      .win_payload (win_ff[2]),
      .cur_cmd     (cmd_ff),
      .cfg         (cfg_ff),
      .res         (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff[0]    <= '0;
         win_ff[1]    <= '0;
         win_ff[2]    <= '0;
         cmd_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         win_ff[0]    <= win_ff[1];
         win_ff[1]    <= win_ff[2];
         win_ff[2]    <= in_byte_ff;
         cmd_ff       <= res_in.command_value;
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance) begin
         out_ff <= res_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.drive_mode;
   assign rsp_tdata  = {3'b000, out_ff.drive_value, out_ff.command_changed,
                        out_ff.command_value, out_ff.addressed, out_ff.frame_valid};

   `PMCD_ASSERT_IMPL(a_addr_needs_valid, clock, reset,
      out_valid_ff && out_ff.addressed, out_ff.frame_valid,
      "addressed beat without valid frame")
   `PMCD_ASSERT_IMPL(a_brake_at_zero, clock, reset,
      out_valid_ff && (out_ff.command_value == 8'sd0),
      (out_ff.drive_mode == pmcd_pkg::MODE_BRAKE) && (out_ff.drive_value == 18'sd0),
      "zero command not braking")
   `PMCD_ASSERT_IMPL(a_duty_range, clock, reset,
      out_valid_ff && (out_ff.drive_mode == pmcd_pkg::MODE_DUTY),
      (out_ff.drive_value <= 18'sd32767) && (out_ff.drive_value >= -18'sd32767),
      "duty outside Q1.15 range")
   `PMCD_ASSERT_NEXT(a_changed_flag, clock, reset,
      !reset && advance,
      (cmd_ff != $past(cmd_ff)) == out_ff.command_changed,
      "command_changed disagrees with stored command")

endmodule
